FILE: design/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
// No dependencies; every other file in this block imports it.
package hpt_pkg;

  localparam int unsigned QW         = 32;  // width of one fixed-point value
  localparam int unsigned PROD_W     = 64;  // exact product of two values
  localparam int unsigned SUM_W      = 66;  // exact sum of four products
  localparam int unsigned NUM_REGS   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned NUM_COLS   = 4;
  localparam int unsigned NUM_ROWS   = 4;
  localparam int unsigned W_ROW      = 3;

  localparam logic signed [QW-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [QW-1:0] q_t;

  // per-lane data that rides alongside the divider stages
  typedef struct packed {
    logic neg;
    q_t   raw;
  } lane_side_t;

endpackage

FILE: design/hpt_stream_if.sv
// Valid/ready channel interfaces for input points and transformed results.
// Depends on hpt_pkg for the value type.
interface hpt_in_if;
  import hpt_pkg::*;
  logic valid;
  logic ready;
  logic kind;
  q_t   in_x;
  q_t   in_y;
  q_t   in_z;
  modport source (output valid, kind, in_x, in_y, in_z, input ready);
  modport sink   (input valid, kind, in_x, in_y, in_z, output ready);
endinterface

interface hpt_out_if;
  import hpt_pkg::*;
  logic valid;
  logic ready;
  q_t   out_x;
  q_t   out_y;
  q_t   out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

FILE: design/homogeneous_point_transform.sv
// Homogeneous 4x4 point transform with perspective divide, Q(32-F).F fixed point.
// Input channel in_ch takes kind and in_x/in_y/in_z; output channel out_ch gives
// out_x/out_y/out_z, one result per item. The matrix is eight 64-bit registers
// written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only
// while the block is idle; the block itself does not enforce this. The
// pipeline has three stages of multiply, sum and saturate, one divider stage
// per quotient bit and the output register; it takes one item per cycle
// while not stalled; it moves as one, so divider depth sets latency, not rate.
// Reset empties the pipeline and loads the identity matrix.
// When the receiver stalls with a result waiting, every stage holds and
// in_ch.ready drops; nothing is lost or repeated. Results that skip the divide
// (w equal to 0 or 1.0) travel the same path and keep their order.
// Uses hpt_pkg, hpt_stream_if, hpt_dot and hpt_div.
module homogeneous_point_transform
  import hpt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hpt_in_if.sink                in_ch,
  hpt_out_if.source             out_ch
);

  localparam int unsigned NUM_W = QW + FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] ONE_HI = CFG_DATA_W'(1) << (FRAC_BITS + QW);

  logic [NUM_REGS-1:0][CFG_DATA_W-1:0] mat_q;
  logic                                adv;
  logic                                v3;
  q_t                                  r3 [NUM_ROWS];
  logic                                do_div;
  logic [QW-1:0]                       w_mag;
  logic                                vld_q [NUM_W];
  logic                                dd_q  [NUM_W];
  logic                                out_valid_q;
  q_t                                  out_q [3];
  q_t                                  res_d [3];

  assign adv         = !out_valid_q || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // identity: 1.0 on the diagonal
      mat_q <= {ONE_HI, CFG_DATA_W'(0), ONE_LO, CFG_DATA_W'(0),
                CFG_DATA_W'(0), ONE_HI, CFG_DATA_W'(0), ONE_LO};
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  hpt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_ch.valid),
    .kind_i  (in_ch.kind),
    .x_i     (in_ch.in_x),
    .y_i     (in_ch.in_y),
    .z_i     (in_ch.in_z),
    .mat_i   (mat_q),
    .valid_o (v3),
    .r_o     (r3)
  );

  assign do_div = (r3[W_ROW] != q_t'(0)) && (r3[W_ROW] != q_t'(1 << FRAC_BITS));

  assign w_mag = r3[W_ROW][QW-1] ? QW'(-r3[W_ROW]) : QW'(r3[W_ROW]);

  // valid and divide flag follow the divider lanes stage by stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_W; s++) begin
        vld_q[s] <= 1'b0;
        dd_q[s]  <= 1'b0;
      end
    end else if (adv) begin
      vld_q[0] <= v3;
      dd_q[0]  <= do_div;
      for (int s = 1; s < NUM_W; s++) begin
        vld_q[s] <= vld_q[s-1];
        dd_q[s]  <= dd_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [QW-1:0]    mag;
    logic [NUM_W-1:0] quot;
    lane_side_t       side_in, side_out;

    assign mag          = r3[l][QW-1] ? QW'(-r3[l]) : QW'(r3[l]);
    assign side_in.neg  = r3[l][QW-1] ^ r3[W_ROW][QW-1];
    assign side_in.raw  = r3[l];

    hpt_div #(.NUM_W(NUM_W)) u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .num_i  ({mag, {FRAC_BITS{1'b0}}}),
      .den_i  (w_mag),
      .side_i (side_in),
      .quot_o (quot),
      .side_o (side_out)
    );

    always_comb begin
      if (!dd_q[NUM_W-1]) begin
        res_d[l] = side_out.raw;
      end else if (side_out.neg) begin
        if (quot > NUM_W'(33'h1_0000_0000 >> 1)) res_d[l] = Q_MIN;
        else                                      res_d[l] = q_t'(-quot[QW-1:0]);
      end else begin
        if (quot > NUM_W'(Q_MAX)) res_d[l] = Q_MAX;
        else                      res_d[l] = q_t'(quot[QW-1:0]);
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) out_q[l] <= res_d[l];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= vld_q[NUM_W-1];
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.out_x = out_q[0];
  assign out_ch.out_y = out_q[1];
  assign out_ch.out_z = out_q[2];

`ifndef ASSERT_OFF
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3 && do_div |-> w_mag != '0)
    else $error("divide issued with zero divisor");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q[NUM_W-1]) && $stable(dd_q[NUM_W-1]))
    else $error("divider tail moved during stall");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken while output stalled");
`endif

endmodule

FILE: design/hpt_dot.sv
// Matrix-vector product: multiply, sum and floor/saturate, three register stages.
// Depends on hpt_pkg.
module hpt_dot
  import hpt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic                                kind_i,
  input  q_t                                  x_i,
  input  q_t                                  y_i,
  input  q_t                                  z_i,
  input  logic [NUM_REGS-1:0][CFG_DATA_W-1:0] mat_i,
  output logic                                valid_o,
  output q_t                                  r_o [NUM_ROWS]
);

  q_t                       vec [NUM_COLS];
  logic signed [PROD_W-1:0] prod_q [NUM_ROWS][NUM_COLS];
  logic signed [SUM_W-1:0]  sum_q  [NUM_ROWS];
  q_t                       r_q    [NUM_ROWS];
  logic                     v1_q, v2_q, v3_q;

  assign vec[0] = x_i;
  assign vec[1] = y_i;
  assign vec[2] = z_i;
  assign vec[3] = kind_i ? q_t'(0) : q_t'(1 << FRAC_BITS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    logic signed [SUM_W-1:0] sh;
    logic signed [SUM_W-1:0] sum_d;
    q_t                      sat;

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      q_t elem;
      assign elem = q_t'(mat_i[c*2 + r/2][(r%2)*QW +: QW]);
      always_ff @(posedge clk_i) begin
        if (en_i) prod_q[r][c] <= PROD_W'(elem) * PROD_W'(vec[c]);
      end
    end

    assign sum_d = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1])
                 + SUM_W'(prod_q[r][2]) + SUM_W'(prod_q[r][3]);

    // floor shift, then clamp to the 32-bit range
    assign sh = sum_q[r] >>> FRAC_BITS;
    always_comb begin
      if (sh > SUM_W'(Q_MAX))      sat = Q_MAX;
      else if (sh < SUM_W'(Q_MIN)) sat = Q_MIN;
      else                         sat = sh[QW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sum_q[r] <= sum_d;
        r_q[r]   <= sat;
      end
    end

    assign r_o[r] = r_q[r];
  end

  assign valid_o = v3_q;

endmodule

FILE: design/hpt_div.sv
// Restoring divider, one quotient bit per register stage, for one lane.
// Depends on hpt_pkg for the side payload type.
module hpt_div
  import hpt_pkg::*;
#(
  parameter int unsigned NUM_W = 48
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [QW-1:0]    den_i,
  input  lane_side_t       side_i,
  output logic [NUM_W-1:0] quot_o,
  output lane_side_t       side_o
);

  logic [QW-1:0]    rem_q  [NUM_W];
  logic [NUM_W-1:0] nq_q   [NUM_W];
  logic [QW-1:0]    den_q  [NUM_W];
  lane_side_t       side_q [NUM_W];

  for (genvar s = 0; s < NUM_W; s++) begin : g_stage
    logic [QW-1:0]    rem_p, den_p;
    logic [NUM_W-1:0] nq_p;
    lane_side_t       side_p;
    logic [QW:0]      trial;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_p  = '0;
      assign nq_p   = num_i;
      assign den_p  = den_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[s-1];
      assign nq_p   = nq_q[s-1];
      assign den_p  = den_q[s-1];
      assign side_p = side_q[s-1];
    end

    assign trial = {rem_p, nq_p[NUM_W-1]};
    assign ge    = trial >= {1'b0, den_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? QW'(trial - {1'b0, den_p}) : trial[QW-1:0];
        nq_q[s]   <= {nq_p[NUM_W-2:0], ge};
        den_q[s]  <= den_p;
        side_q[s] <= side_p;
      end
    end
  end

  assign quot_o = nq_q[NUM_W-1];
  assign side_o = side_q[NUM_W-1];

endmodule

FILE: tb/tb_homogeneous_point_transform.sv
// Self-checking bench for the homogeneous point transform: matrix writes, directed
// and random points and directions, checked against an in-bench fixed-point model.
// Depends on hpt_pkg, hpt_stream_if and the homogeneous_point_transform RTL.
module tb_homogeneous_point_transform;
  import hpt_pkg::*;

  localparam int FB = 16;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam int unsigned LIMIT_CYC = 400000;
  localparam int unsigned DRAIN_CYC = 80;
  localparam int N_DIR = 12;
  localparam int N_RAND = 750;

  typedef enum logic {KIND_POINT = 1'b0, KIND_DIR = 1'b1} kind_e;
  typedef enum logic [CFG_IDX_W-1:0] {
    R_C0_01, R_C0_23, R_C1_01, R_C1_23, R_C2_01, R_C2_23, R_C3_01, R_C3_23
  } reg_e;

  typedef struct packed {
    kind_e kind;
    q_t    x, y, z;
  } vtx_t;
  typedef struct packed {
    q_t x, y, z;
  } res_t;
  typedef struct packed {
    vtx_t v;
    logic known;
    res_t r;
  } row_t;

  logic clk_i, rst_ni, cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  hpt_in_if  in_ch ();
  hpt_out_if out_ch ();

  homogeneous_point_transform u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  logic [63:0] mat_regs [NUM_REGS];
  res_t exp_q [$];
  int errors = 0;
  int unsigned cyc = 0;
  bit no_idle = 0;
  bit drain_done = 0;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [63:0] mat_elem(int col, int row);
    logic [63:0] r;
    r = mat_regs[col*2 + row/2];
    return (row % 2) ? {{32{r[63]}}, r[63:32]} : {{32{r[31]}}, r[31:0]};
  endfunction

  function automatic logic signed [63:0] sat_q(logic signed [127:0] s);
    if (s > 128'sh7fff_ffff) return 64'sh7fff_ffff;
    if (s < -128'sh8000_0000) return -64'sh8000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] fx_div(logic signed [63:0] n, logic signed [63:0] d);
    logic [127:0] mn, md, qq;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    qq = (mn << FB) / md;
    if ((n < 0) != (d < 0)) return qq > 128'h8000_0000 ? -64'sh8000_0000 : -$signed(qq[63:0]);
    return qq > 128'h7fff_ffff ? 64'sh7fff_ffff : qq[63:0];
  endfunction

  function automatic res_t transform_vertex(vtx_t v);
    logic signed [63:0] vin [4];
    logic signed [63:0] r [4];
    logic signed [127:0] acc;
    res_t o;
    vin[0] = v.x; vin[1] = v.y; vin[2] = v.z;
    vin[3] = (v.kind == KIND_DIR) ? 0 : 64'(ONE);
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += 128'(mat_elem(c, row)) * 128'(vin[c]);
      r[row] = sat_q(acc >>> FB);
    end
    if (r[3] != 0 && r[3] != 64'(ONE))
      for (int i = 0; i < 3; i++) r[i] = fx_div(r[i], r[3]);
    o.x = r[0][31:0]; o.y = r[1][31:0]; o.z = r[2][31:0];
    return o;
  endfunction

  // Cycle counter and result checker
  always @(posedge clk_i) begin
    res_t got, want;
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYC) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_x, out_ch.out_y, out_ch.out_z};
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = exp_q.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: x expected %h actual %h", $time, want.x, got.x); errors++;
        end
        if (got.y !== want.y) begin
          $display("%0t: y expected %h actual %h", $time, want.y, got.y); errors++;
        end
        if (got.z !== want.z) begin
          $display("%0t: z expected %h actual %h", $time, want.z, got.z); errors++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    out_ch.ready <= (no_idle || drain_done) ? 1'b1 : ($urandom_range(99) >= 23);
  end

  task automatic write_reg(reg_e idx, logic [63:0] d);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= d;
    mat_regs[idx] = d;
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 0;
    while (exp_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic load_matrix(logic [63:0] m [NUM_REGS]);
    wait_idle();
    for (int i = 0; i < NUM_REGS; i++) write_reg(reg_e'(i), m[i]);
    cfg_we_i <= 0;
  endtask

  // Present one item, idling at random, and hold until accepted
  task automatic send_vertex(vtx_t v, logic known, res_t r);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_ch.valid <= 0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1; in_ch.kind <= v.kind;
    in_ch.in_x <= v.x; in_ch.in_y <= v.y; in_ch.in_z <= v.z;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    exp_q.push_back(known ? r : transform_vertex(v));
    @(negedge clk_i);
  endtask

  function automatic q_t rand_q(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $urandom_range(1) ? Q_MAX : Q_MIN;
      default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  function automatic logic [63:0] rand_pair(int mode);
    return {rand_q(mode), rand_q(mode)};
  endfunction

  row_t dir_rows [N_DIR];
  logic [63:0] mset [NUM_REGS];

  initial begin
    vtx_t v;
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = R_C0_01; cfg_data_i = 0;
    in_ch.valid = 0; in_ch.kind = KIND_POINT; in_ch.in_x = 0; in_ch.in_y = 0;
    in_ch.in_z = 0; out_ch.ready = 0;
    mat_regs = '{64'(ONE), 0, 64'(ONE) << 32, 0, 0, 64'(ONE), 0, 64'(ONE) << 32};
    // Identity after reset: known rows give results directly, others use the model
    dir_rows = '{
      '{'{KIND_POINT, 32'sd0, 32'sd0, 32'sd0}, 1, '{32'sd0, 32'sd0, 32'sd0}},
      '{'{KIND_POINT, Q_MAX, Q_MIN, Q_MAX}, 1, '{Q_MAX, Q_MIN, Q_MAX}},
      '{'{KIND_DIR, Q_MIN, Q_MAX, -32'sd1}, 1, '{Q_MIN, Q_MAX, -32'sd1}},
      '{'{KIND_DIR, 32'sd1, 32'sd0, 32'sd0}, 1, '{32'sd1, 32'sd0, 32'sd0}},
      '{'{KIND_POINT, 32'sh0001_8000, -32'sh0002_0000, 32'sd7}, 1,
        '{32'sh0001_8000, -32'sh0002_0000, 32'sd7}},
      '{'{KIND_POINT, -32'sd1, -32'sd1, -32'sd1}, 1, '{-32'sd1, -32'sd1, -32'sd1}},
      '{'{KIND_DIR, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd0}, 1,
        '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sd0}},
      '{'{KIND_POINT, 32'sh1234_5678, 32'sh0, -32'sh0765_4321}, 0, '0},
      '{'{KIND_DIR, 32'sh0000_ffff, 32'sh7fff_0000, 32'sh8000_0001}, 0, '0},
      '{'{KIND_POINT, Q_MIN, Q_MIN, Q_MIN}, 0, '0},
      '{'{KIND_DIR, Q_MAX, Q_MAX, Q_MAX}, 0, '0},
      '{'{KIND_POINT, 32'sh0003_0000, 32'sh0000_4000, -32'sh0000_0100}, 0, '0}
    };
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_vertex(dir_rows[i].v, dir_rows[i].known, dir_rows[i].r);

    // Perspective matrix: w row taken from z, so divides happen
    mset = '{64'(ONE), 0, 64'(ONE) << 32, 0, 0, {32'(ONE), 32'(ONE)}, 0, 0};
    load_matrix(mset);
    foreach (dir_rows[i]) send_vertex(dir_rows[i].v, 0, '0);
    v = '{KIND_POINT, 32'sh0002_0000, 32'sd0, -32'sh0000_0001};  // tiny negative w
    send_vertex(v, 0, '0);
    v = '{KIND_DIR, Q_MAX, Q_MIN, 32'sd1};
    send_vertex(v, 0, '0);

    // Full-scale extremes in most registers
    mset = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_7FFF_FFFF, 64'h7FFF_FFFF_8000_0000,
             64'h0, 64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF,
             64'hFFFF_FFFF_0000_0001, 64'h0001_0000_8000_0000};
    load_matrix(mset);
    foreach (dir_rows[i]) send_vertex(dir_rows[i].v, 0, '0);

    // Random phases; wait for full drain before each matrix change
    for (int n = 0; n < N_RAND; n++) begin
      if (n % 125 == 0) begin
        for (int i = 0; i < NUM_REGS; i++) mset[i] = rand_pair($urandom_range(3));
        if ($urandom_range(1)) mset[7] = {32'(ONE), rand_q(1)};
        if (n == 250) mset[7] = 64'h0;
        load_matrix(mset);
      end
      no_idle = (n >= 400 && n < 500);
      v.kind = kind_e'($urandom_range(1));
      v.x = rand_q($urandom_range(3));
      v.y = rand_q($urandom_range(3));
      v.z = rand_q($urandom_range(3));
      send_vertex(v, 0, '0);
      if (n == 600) begin
        // hold back until the pipeline is empty
        in_ch.valid <= 0;
        while (exp_q.size() != 0) @(negedge clk_i);
      end
    end
    no_idle = 0;

    in_ch.valid <= 0;
    while (exp_q.size() != 0) @(negedge clk_i);
    drain_done = 1;
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (errors == 0 && exp_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: homogeneous_point_transform.f
design/hpt_pkg.sv
design/hpt_stream_if.sv
design/hpt_dot.sv
design/hpt_div.sv
design/homogeneous_point_transform.sv
tb/tb_homogeneous_point_transform.sv
